@@ rtl/core/spi_burst_register_slave_core_macros.svh @@
// assertion macros shared by the spi burst register slave core
`ifndef SPI_BURST_REGISTER_SLAVE_CORE_MACROS_SVH
`define SPI_BURST_REGISTER_SLAVE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SBRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/sbrs_pkg.sv @@
// types and constants of the spi burst register slave core
package sbrs_pkg;

    // default address width of the register store
    localparam int ADDR_BITS_DEF = 16;

    // header field layout
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 15;
    localparam int LEN_HI_W   = 7;
    localparam int WRITE_BIT  = 7;

    // frame phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ADDR_LO,
        PH_CTRL,
        PH_LEN_LO,
        PH_DATA
    } t_phase;

    // store access issued with an accepted word
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_req;

    // per-word control carried to the output side
    typedef struct packed {
        logic rd;
        logic data_phase;
        logic last;
    } t_stage_info;

endpackage

@@ rtl/core/sbrs_in_if.sv @@
// input channel: one spi byte exchanged with the master
interface sbrs_in_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] mosi_byte;

    modport source (output valid, output frame_start, output mosi_byte, input ready);
    modport sink   (input valid, input frame_start, input mosi_byte, output ready);
endinterface

@@ rtl/core/sbrs_out_if.sv @@
// output channel: byte returned to the master plus frame flags
interface sbrs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] miso_byte;
    logic       data_phase;
    logic       last_data;

    modport source (output valid, output miso_byte, output data_phase, output last_data,
                    input ready);
    modport sink   (input valid, input miso_byte, input data_phase, input last_data,
                    output ready);
endinterface

@@ rtl/core/sbrs_ram.sv @@
// generic single-port ram with registered read
module sbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/sbrs_frame_ctrl.sv @@
// frame decoder: header parsing, address and length counters, store access
module sbrs_frame_ctrl #(
    parameter int ADDR_BITS = sbrs_pkg::ADDR_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_frame_start,
    input  logic [7:0]            i_mosi_byte,
    output sbrs_pkg::t_mem_req    o_mem,
    output logic [ADDR_BITS-1:0]  o_addr,
    output sbrs_pkg::t_stage_info o_info
);
    import sbrs_pkg::*;

    t_phase               r_phase, n_phase;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [LEN_W-1:0]     r_left, n_left;
    logic                 r_write, n_write;
    logic [LEN_W-1:0]     w_len_full;

    // full length once the low byte arrives
    assign w_len_full = {r_left[LEN_W-1:BYTE_W], i_mosi_byte};

    // next state
    always_comb begin
        n_phase = r_phase;
        n_addr  = r_addr;
        n_left  = r_left;
        n_write = r_write;
        if (i_accept) begin
            if (i_frame_start) begin
                // a new frame always restarts the header
                n_addr  = ADDR_BITS'({i_mosi_byte, 8'h00});
                n_left  = '0;
                n_write = 1'b0;
                n_phase = PH_ADDR_LO;
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_phase = PH_IDLE;
                    end
                    PH_ADDR_LO: begin
                        n_addr  = r_addr | ADDR_BITS'(i_mosi_byte);
                        n_phase = PH_CTRL;
                    end
                    PH_CTRL: begin
                        n_write = i_mosi_byte[WRITE_BIT];
                        n_left  = {i_mosi_byte[LEN_HI_W-1:0], 8'h00};
                        n_phase = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        n_left  = w_len_full;
                        n_phase = (w_len_full == '0) ? PH_IDLE : PH_DATA;
                    end
                    PH_DATA: begin
                        n_addr = r_addr + ADDR_BITS'(1);
                        n_left = r_left - LEN_W'(1);
                        if (r_left == LEN_W'(1)) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // store access and word flags
    always_comb begin
        o_mem  = '0;
        o_info = '0;
        if (i_accept && !i_frame_start) begin
            case (r_phase)
                PH_DATA: begin
                    o_mem.we          = r_write;
                    o_mem.re          = !r_write;
                    o_info.rd         = !r_write;
                    o_info.data_phase = 1'b1;
                    o_info.last       = (r_left == LEN_W'(1));
                end
                default: begin
                    o_mem  = '0;
                    o_info = '0;
                end
            endcase
        end
    end

    assign o_addr = r_addr;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_addr  <= '0;
            r_left  <= '0;
            r_write <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_addr  <= n_addr;
            r_left  <= n_left;
            r_write <= n_write;
        end
    end
endmodule

@@ rtl/core/spi_burst_register_slave_core.sv @@
// top level of the spi burst register slave core
// Channels: i_byte takes one word per spi byte exchanged while chip select is
// low (frame_start marks the first byte of a frame); o_result returns one word
// per input word with the miso byte and the data phase / last data flags.
// A frame is address high, address low, control (bit 7 write, length 14..8),
// length low, then the data bytes, stored or read at an auto-incrementing
// address that wraps at 2^ADDR_BITS.
// Pipeline: an accepted input word passes the registered store read and then the
// output register before its result leaves.
// Throughput: one word per cycle when not stalled; the store has a single port
// and each word makes at most one access to it, in the cycle it is accepted.
// A write is followed by a read of the store at the earliest five words later
// (a new header sits between), so no forwarding is needed.
// Reset: the frame decoder returns to idle with address and length cleared;
// the store is not cleared and reading an unwritten location is undefined.
// Stall: when o_result is held off, the word in the read stage keeps its data
// and i_byte.ready drops only once both the read stage and the output
// register are full.
`include "spi_burst_register_slave_core_macros.svh"

module spi_burst_register_slave_core #(
    parameter int ADDR_BITS = sbrs_pkg::ADDR_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sbrs_in_if.sink    i_byte,
    sbrs_out_if.source o_result
);
    import sbrs_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic                 w_accept;
    logic                 w_s1_adv;
    t_mem_req             w_mem;
    logic [ADDR_BITS-1:0] w_addr;
    t_stage_info          w_info;
    logic [7:0]           w_rdata;

    logic                 r_s1_valid, n_s1_valid;
    t_stage_info          r_s1_info;
    logic                 r_out_valid;
    logic [7:0]           r_out_miso;
    logic                 r_out_dphase;
    logic                 r_out_last;

    // handshake: the read stage moves on when the output register is free or being taken
    assign w_s1_adv     = !r_out_valid || o_result.ready;
    assign i_byte.ready = !r_s1_valid || w_s1_adv;
    assign w_accept     = i_byte.valid && i_byte.ready;

    // frame decoder
    sbrs_frame_ctrl #(
        .ADDR_BITS (ADDR_BITS)
    ) u_frame_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_frame_start (i_byte.frame_start),
        .i_mosi_byte   (i_byte.mosi_byte),
        .o_mem         (w_mem),
        .o_addr        (w_addr),
        .o_info        (w_info)
    );

    // register store
    sbrs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_re    (w_mem.re),
        .i_addr  (w_addr),
        .i_wdata (i_byte.mosi_byte),
        .o_rdata (w_rdata)
    );

    // read stage occupancy
    always_comb begin
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    // read stage and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (w_s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // read stage and output register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_info <= w_info;
        end
        if (w_s1_adv && r_s1_valid) begin
            r_out_miso   <= r_s1_info.rd ? w_rdata : 8'h00;
            r_out_dphase <= r_s1_info.data_phase;
            r_out_last   <= r_s1_info.last;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.miso_byte  = r_out_miso;
    assign o_result.data_phase = r_out_dphase;
    assign o_result.last_data  = r_out_last;

    // checks
    `SBRS_ASSERT_NEXT(a_stall_holds_read, i_clk, i_rst_n, r_s1_valid && !w_s1_adv, r_s1_valid && $stable(w_rdata), "read stage lost its data while stalled")
    `SBRS_ASSERT_NOW(a_single_access, i_clk, i_rst_n, w_mem.we, !w_mem.re && w_accept, "store write without accepted word or with a read")
    `SBRS_ASSERT_NOW(a_last_in_data, i_clk, i_rst_n, o_result.valid && o_result.last_data, o_result.data_phase, "last data flag outside data phase")
    `SBRS_ASSERT_NOW(a_miso_zero_hdr, i_clk, i_rst_n, o_result.valid && !o_result.data_phase, o_result.miso_byte == 8'h00, "nonzero miso byte outside data phase")
endmodule
